FILE: src/pulse_rate_estimator_assert.svh
// Assertion macros used by the pulse rate estimator RTL.
`ifndef PULSE_RATE_ESTIMATOR_ASSERT_SVH
`define PULSE_RATE_ESTIMATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define PRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PRE_ASSERT(label, prop, msg)
`define PRE_ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: src/pre_pkg.sv
// Shared constants, types and saturation helpers of the pulse rate estimator.
package pre_pkg;

  localparam int SAMPLE_BITS = 18;
  localparam int RAW_W       = 18;
  localparam int TIME_W      = 32;
  localparam int FILT_W      = 32;
  localparam int RATE_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_BETA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 3'd4;

  // register reset values
  localparam logic [15:0] RST_DC_ALPHA    = 16'd62259;
  localparam logic [15:0] RST_SMOOTH_BETA = 16'd16384;
  localparam logic [30:0] RST_PEAK_THRESH = 31'd66;
  localparam logic [15:0] RST_MIN_GAP     = 16'd250;
  localparam logic [15:0] RST_MAX_GAP     = 16'd1500;

  // rate arithmetic
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [23:0] RATE_NUM         = 24'd15360000;  // 60000 * 256
  localparam logic [15:0] RATE_MAX         = 16'hFFFF;
  localparam logic [15:0] RATE_FIRST_LIMIT = 16'd2560;      // 10 bpm in Q8.8
  localparam logic [20:0] RECIP5           = 21'd838861;    // ceil(2^22 / 5)
  localparam int RECIP5_SHIFT = 22;

  // datapath operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_MLO  = 4'd1;
  localparam logic [OP_W-1:0] OP_MHI  = 4'd2;
  localparam logic [OP_W-1:0] OP_WACC = 4'd3;
  localparam logic [OP_W-1:0] OP_WSAT = 4'd4;
  localparam logic [OP_W-1:0] OP_DSAT = 4'd5;
  localparam logic [OP_W-1:0] OP_DIFF = 4'd6;
  localparam logic [OP_W-1:0] OP_MS   = 4'd7;
  localparam logic [OP_W-1:0] OP_SSAT = 4'd8;
  localparam logic [OP_W-1:0] OP_PEAK = 4'd9;
  localparam logic [OP_W-1:0] OP_CHK  = 4'd10;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd11;
  localparam logic [OP_W-1:0] OP_RATE = 4'd12;
  localparam logic [OP_W-1:0] OP_MAVG = 4'd13;
  localparam logic [OP_W-1:0] OP_AVG  = 4'd14;

  typedef struct packed {
    logic [15:0] dc_alpha;
    logic [15:0] smooth_beta;
    logic [30:0] peak_threshold;
    logic [15:0] min_gap_ms;
    logic [15:0] max_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic            load_in;
    logic [OP_W-1:0] op;
    logic            load_out;
  } cmd_t;

  typedef struct packed {
    logic beat_ok;
    logic avg_needed;
  } stat_t;

  function automatic logic signed [39:0] sat40(input logic signed [42:0] v);
    logic signed [39:0] r;
    if (v[42:39] == 4'b0000 || v[42:39] == 4'b1111) begin
      r = v[39:0];
    end else if (v[42]) begin
      r = {1'b1, 39'b0};
    end else begin
      r = {1'b0, {39{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v[40:31] == 10'h000 || v[40:31] == 10'h3FF) begin
      r = v[31:0];
    end else if (v[40]) begin
      r = {1'b1, 31'b0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/pre_cfg.sv
// Configuration register file of the pulse rate estimator.
module pre_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pre_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pre_pkg::cfg_t                     cfg
);

  pre_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dc_alpha       <= pre_pkg::RST_DC_ALPHA;
      cfg_r.smooth_beta    <= pre_pkg::RST_SMOOTH_BETA;
      cfg_r.peak_threshold <= pre_pkg::RST_PEAK_THRESH;
      cfg_r.min_gap_ms     <= pre_pkg::RST_MIN_GAP;
      cfg_r.max_gap_ms     <= pre_pkg::RST_MAX_GAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pre_pkg::REG_DC_ALPHA:    cfg_r.dc_alpha       <= cfg_data[15:0];
        pre_pkg::REG_SMOOTH_BETA: cfg_r.smooth_beta    <= cfg_data[15:0];
        pre_pkg::REG_PEAK_THRESH: cfg_r.peak_threshold <= cfg_data[30:0];
        pre_pkg::REG_MIN_GAP:     cfg_r.min_gap_ms     <= cfg_data[15:0];
        pre_pkg::REG_MAX_GAP:     cfg_r.max_gap_ms     <= cfg_data[15:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

FILE: src/pre_datapath.sv
// Filter, peak detector and rate datapath with one shared multiplier and a serial divider.
module pre_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pre_pkg::cfg_t                   cfg,
  input  pre_pkg::cmd_t                   cmd,
  input  logic [pre_pkg::RAW_W-1:0]       in_raw,
  input  logic [pre_pkg::TIME_W-1:0]      in_time,
  output pre_pkg::stat_t                  stat,
  output logic [pre_pkg::FILT_W-1:0]      out_filtered,
  output logic [pre_pkg::RATE_W-1:0]      out_rate,
  output logic                            out_peak,
  output logic                            out_used
);

  // item inputs
  logic [pre_pkg::SAMPLE_BITS-1:0] x_r;
  logic [31:0]                     t_r;

  // block state
  logic signed [39:0] w_r;
  logic signed [31:0] s_r;
  logic signed [31:0] prev_r;
  logic               rising_r;
  logic [31:0]        last_r;
  logic               valid_r;
  logic [15:0]        rate_r;

  // working registers
  logic signed [39:0] wold_r;
  logic signed [57:0] acc_r;
  logic signed [54:0] prod_r;
  logic signed [31:0] d_r;
  logic signed [32:0] diff_r;
  logic               peak_r;
  logic               used_r;
  logic [31:0]        gap_r;
  logic [23:0]        num_r;
  logic [15:0]        rem_r;
  logic [18:0]        navg_r;

  // shared multiplier
  logic signed [20:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [54:0] mul_p;

  logic signed [42:0] x_fix;
  logic signed [42:0] w_sum;
  logic signed [31:0] thr_s;
  logic               peak_now;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic [15:0]        raw_rate;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      pre_pkg::OP_MLO: begin
        mul_a = $signed({5'b0, cfg.dc_alpha});
        mul_b = $signed({14'b0, w_r[19:0]});
      end
      pre_pkg::OP_MHI: begin
        mul_a = $signed({5'b0, cfg.dc_alpha});
        mul_b = $signed({{14{w_r[39]}}, w_r[39:20]});
      end
      pre_pkg::OP_MS: begin
        mul_a = $signed({5'b0, cfg.smooth_beta});
        mul_b = $signed({diff_r[32], diff_r});
      end
      pre_pkg::OP_MAVG: begin
        mul_a = $signed(pre_pkg::RECIP5);
        mul_b = $signed({15'b0, navg_r});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign x_fix    = $signed(43'({x_r, 16'b0}));
  assign w_sum    = x_fix + 43'(acc_r >>> 16);
  assign thr_s    = $signed({1'b0, cfg.peak_threshold});
  assign peak_now = rising_r && (s_r < prev_r) && (prev_r > thr_s);
  assign rem_sh   = {rem_r, num_r[23]};
  assign rem_ge   = rem_sh >= {1'b0, gap_r[15:0]};
  assign raw_rate = (num_r > 24'(pre_pkg::RATE_MAX)) ? pre_pkg::RATE_MAX : num_r[15:0];

  assign stat.beat_ok = peak_r && valid_r && (gap_r != 32'd0) &&
                        (gap_r >= {16'b0, cfg.min_gap_ms}) &&
                        (gap_r <= {16'b0, cfg.max_gap_ms});
  assign stat.avg_needed = rate_r >= pre_pkg::RATE_FIRST_LIMIT;

  // state that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= '0;
      s_r      <= '0;
      prev_r   <= '0;
      rising_r <= 1'b0;
      last_r   <= '0;
      valid_r  <= 1'b0;
      rate_r   <= '0;
    end else begin
      case (cmd.op)
        pre_pkg::OP_WSAT: w_r <= pre_pkg::sat40(w_sum);
        pre_pkg::OP_SSAT: s_r <= pre_pkg::sat32(41'(s_r) + 41'(prod_r >>> 16));
        pre_pkg::OP_PEAK: begin
          if (peak_now) begin
            rising_r <= 1'b0;
          end else if (s_r > prev_r) begin
            rising_r <= 1'b1;
          end
          prev_r <= s_r;
        end
        pre_pkg::OP_CHK: begin
          if (peak_r) begin
            last_r  <= t_r;
            valid_r <= 1'b1;
          end
        end
        pre_pkg::OP_RATE: begin
          if (!stat.avg_needed) begin
            rate_r <= raw_rate;
          end
        end
        pre_pkg::OP_AVG: rate_r <= prod_r[pre_pkg::RECIP5_SHIFT +: 16];
        default: ;
      endcase
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= in_raw[pre_pkg::SAMPLE_BITS-1:0];
      t_r <= in_time;
    end
    case (cmd.op)
      pre_pkg::OP_MLO:  prod_r <= mul_p;
      pre_pkg::OP_MHI: begin
        acc_r  <= 58'(prod_r);
        prod_r <= mul_p;
      end
      pre_pkg::OP_WACC: acc_r  <= acc_r + (58'(prod_r) <<< 20);
      pre_pkg::OP_WSAT: wold_r <= w_r;
      pre_pkg::OP_DSAT: d_r    <= pre_pkg::sat32(41'(w_r) - 41'(wold_r));
      pre_pkg::OP_DIFF: diff_r <= 33'(d_r) - 33'(s_r);
      pre_pkg::OP_MS:   prod_r <= mul_p;
      pre_pkg::OP_PEAK: begin
        peak_r <= peak_now;
        gap_r  <= t_r - last_r;
      end
      pre_pkg::OP_CHK: begin
        used_r <= stat.beat_ok;
        num_r  <= pre_pkg::RATE_NUM + 24'(gap_r[15:1]);
        rem_r  <= '0;
      end
      pre_pkg::OP_DIV: begin
        if (rem_ge) begin
          rem_r <= 16'(rem_sh - {1'b0, gap_r[15:0]});
          num_r <= {num_r[22:0], 1'b1};
        end else begin
          rem_r <= rem_sh[15:0];
          num_r <= {num_r[22:0], 1'b0};
        end
      end
      pre_pkg::OP_RATE: navg_r <= 19'({rate_r, 2'b00}) + 19'(raw_rate) + 19'd2;
      pre_pkg::OP_MAVG: prod_r <= mul_p;
      default: ;
    endcase
    if (cmd.load_out) begin
      out_filtered <= s_r;
      out_rate     <= rate_r;
      out_peak     <= peak_r;
      out_used     <= used_r;
    end
  end

endmodule

FILE: src/pre_ctrl.sv
// Sequencing state machine and output handshake of the pulse rate estimator.
`include "pulse_rate_estimator_assert.svh"
module pre_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  pre_pkg::stat_t stat,
  output pre_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MLO  = 4'd1;
  localparam logic [3:0] S_MHI  = 4'd2;
  localparam logic [3:0] S_WACC = 4'd3;
  localparam logic [3:0] S_WSAT = 4'd4;
  localparam logic [3:0] S_DSAT = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_MS   = 4'd7;
  localparam logic [3:0] S_SSAT = 4'd8;
  localparam logic [3:0] S_PEAK = 4'd9;
  localparam logic [3:0] S_CHK  = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_RATE = 4'd12;
  localparam logic [3:0] S_MAVG = 4'd13;
  localparam logic [3:0] S_AVG  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam logic [pre_pkg::DIV_CNT_W-1:0] CNT_LAST =
    pre_pkg::DIV_CNT_W'(pre_pkg::DIV_STEPS - 1);

  logic [3:0]                    state_r, state_nxt;
  logic [pre_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          accept;
  logic                          out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_WACC;
      S_WACC: state_nxt = S_WSAT;
      S_WSAT: state_nxt = S_DSAT;
      S_DSAT: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MS;
      S_MS:   state_nxt = S_SSAT;
      S_SSAT: state_nxt = S_PEAK;
      S_PEAK: state_nxt = S_CHK;
      S_CHK: begin
        cnt_nxt   = '0;
        state_nxt = stat.beat_ok ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_RATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RATE: state_nxt = stat.avg_needed ? S_MAVG : S_DONE;
      S_MAVG: state_nxt = S_AVG;
      S_AVG:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_in  = accept;
    cmd.load_out = (state_r == S_DONE) && out_free;
    unique case (state_r)
      S_MLO:   cmd.op = pre_pkg::OP_MLO;
      S_MHI:   cmd.op = pre_pkg::OP_MHI;
      S_WACC:  cmd.op = pre_pkg::OP_WACC;
      S_WSAT:  cmd.op = pre_pkg::OP_WSAT;
      S_DSAT:  cmd.op = pre_pkg::OP_DSAT;
      S_DIFF:  cmd.op = pre_pkg::OP_DIFF;
      S_MS:    cmd.op = pre_pkg::OP_MS;
      S_SSAT:  cmd.op = pre_pkg::OP_SSAT;
      S_PEAK:  cmd.op = pre_pkg::OP_PEAK;
      S_CHK:   cmd.op = pre_pkg::OP_CHK;
      S_DIV:   cmd.op = pre_pkg::OP_DIV;
      S_RATE:  cmd.op = pre_pkg::OP_RATE;
      S_MAVG:  cmd.op = pre_pkg::OP_MAVG;
      S_AVG:   cmd.op = pre_pkg::OP_AVG;
      default: cmd.op = pre_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PRE_ASSERT(a_div_cnt_range, (state_r == S_DIV) |-> (cnt_r <= CNT_LAST), "divider count overrun")
  `PRE_ASSERT(a_load_sets_valid, cmd.load_out |=> out_valid_r, "loaded result not presented")
  `PRE_ASSERT(a_no_beat_skips_div, (state_r == S_CHK && !stat.beat_ok) |=> (state_r == S_DONE), "rate path entered without beat")
  `PRE_ASSERT_NEVER(a_no_overwrite, out_valid_r && !out_tready && cmd.load_out, "pending result overwritten")

endmodule

FILE: src/pulse_rate_estimator.sv
// Each input beat passes the filter and peak steps; a used beat then runs the rate divide,
// and the averaging steps follow when a beat is averaged into the rate instead of setting it.
// One item at a time: the input is not ready again until the result is loaded; the 24-step
// serial rate divider and the shared multiplier, used four times per item at most, set this.
// Reset (rst_n, synchronous, active low) clears filter, peak and rate state and
// loads the register defaults; there is no clearing pass.
module pulse_rate_estimator (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pre_pkg::IN_TDATA_W-1:0]     in_tdata,   // [17:0] raw_sample, [49:18] time_ms
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pre_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [31:0] filtered_out, [47:32] rate_bpm
  output logic [pre_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [0] peak_seen, [1] beat_used
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pre_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pre_pkg::cfg_t  cfg;
  pre_pkg::cmd_t  cmd;
  pre_pkg::stat_t stat;

  logic [pre_pkg::FILT_W-1:0] out_filtered;
  logic [pre_pkg::RATE_W-1:0] out_rate;
  logic                       out_peak;
  logic                       out_used;

  // register file; writes are expected only while no item is in flight
  pre_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: one item at a time, the result register frees the input side
  // while a finished beat waits on the output
  pre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // DC removal, low-pass, peak test, interval-to-rate divide and averaging
  pre_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .in_raw       (in_tdata[17:0]),
    .in_time      (in_tdata[49:18]),
    .stat         (stat),
    .out_filtered (out_filtered),
    .out_rate     (out_rate),
    .out_peak     (out_peak),
    .out_used     (out_used)
  );

  assign out_tdata = {out_rate, out_filtered};
  assign out_tuser = {out_used, out_peak};

endmodule
